// ----- rtl/cosine_polyline_resampler_assert.svh -----
// ----------------------------------------------------------------------------
// Resampler assertion macros
// Concurrent assertion shorthands clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COSINE_POLYLINE_RESAMPLER_ASSERT_SVH
`define COSINE_POLYLINE_RESAMPLER_ASSERT_SVH

// Same-cycle implication.
`define CPR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define CPR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/cpr_pkg.sv -----
// ----------------------------------------------------------------------------
// Resampler package
// Shared widths, codes, unit interface types and the cosine blend table.
// ----------------------------------------------------------------------------
package cpr_pkg;

    localparam int MAX_PER_INTERVAL = 63;
    localparam int COS_TABLE_SIZE   = 256;

    localparam int N_W     = $clog2(MAX_PER_INTERVAL + 1);
    localparam int TAB_W   = $clog2(COS_TABLE_SIZE + 1);
    localparam int BLEND_W = 17;
    localparam int COORD_W = 32;
    localparam int MAG_W   = 33;
    localparam int LEN2_W  = 66;
    localparam int SEG2_W  = 24;
    localparam int RAD_W   = 90;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = 48;
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int DIV_STEPS  = MAG_W;
    localparam int CNT_W      = $clog2(SQRT_STEPS + 1);

    localparam logic MODE_DIV  = 1'b0;
    localparam logic MODE_SQRT = 1'b1;

    localparam logic [0:0] CFG_SPAN_X   = 1'd0;
    localparam logic [0:0] CFG_SEGMENTS = 1'd1;

    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint unsigned PI_Q30  = 64'd3373259426;

    typedef logic [BLEND_W-1:0] t_blend_tab [0:COS_TABLE_SIZE];

    typedef struct packed {
        logic             start;
        logic             mode;
        logic [RAD_W-1:0] a;
        logic [N_W:0]     d;
    } t_iter_req;

    typedef struct packed {
        logic              busy;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
    } t_iter_res;

    function automatic longint unsigned cos_q30(input longint unsigned ang);
        longint unsigned x2;
        longint unsigned r;
        longint unsigned t;
        longint unsigned term;
        int k;
        x2 = (ang * ang + (64'd1 << 29)) >> 30;
        r  = Q30_ONE;
        for (k = 0; k < 6; k++) begin
            t = (x2 * r) >> 30;
            case (k)
                0:       term = t / 64'd132;
                1:       term = t / 64'd90;
                2:       term = t / 64'd56;
                3:       term = t / 64'd30;
                4:       term = t / 64'd12;
                default: term = t / 64'd2;
            endcase
            if (term > Q30_ONE) begin
                term = Q30_ONE;
            end
            r = Q30_ONE - term;
        end
        return r;
    endfunction

    function automatic t_blend_tab build_blend_tab();
        t_blend_tab      tab;
        longint unsigned v;
        longint unsigned ang;
        int              j;
        for (j = 0; j <= COS_TABLE_SIZE; j++) begin
            if (2 * j <= COS_TABLE_SIZE) begin
                ang = PI_Q30 * 64'(j) / COS_TABLE_SIZE;
                v   = Q30_ONE - cos_q30(ang);
            end else begin
                ang = PI_Q30 * 64'(COS_TABLE_SIZE - j) / COS_TABLE_SIZE;
                v   = Q30_ONE + cos_q30(ang);
            end
            tab[j] = BLEND_W'((v + (64'd1 << 14)) >> 15);
        end
        return tab;
    endfunction

    localparam t_blend_tab BLEND_TAB = build_blend_tab();

endpackage

// ----- rtl/cpr_mul.sv -----
// ----------------------------------------------------------------------------
// Resampler multiplier
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module cpr_mul (
    input  logic                         i_clk,
    input  logic [cpr_pkg::MUL_A_W-1:0]  i_a,
    input  logic [cpr_pkg::MUL_B_W-1:0]  i_b,
    output logic [cpr_pkg::PROD_W-1:0]   o_p
);

    logic [cpr_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= cpr_pkg::PROD_W'(i_a) * cpr_pkg::PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// ----- rtl/cpr_iter.sv -----
// ----------------------------------------------------------------------------
// Resampler compare-subtract unit
// Restoring square root or division, one result bit per cycle.
// ----------------------------------------------------------------------------
module cpr_iter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cpr_pkg::t_iter_req i_req,
    output cpr_pkg::t_iter_res o_res
);

    logic                        r_busy;
    logic                        r_mode;
    logic [cpr_pkg::CNT_W-1:0]   r_cnt;
    logic [cpr_pkg::RAD_W-1:0]   r_a;
    logic [cpr_pkg::N_W:0]       r_d;
    logic [cpr_pkg::ROOT_W-1:0]  r_root;
    logic [cpr_pkg::REM_W-1:0]   r_rem;

    logic [cpr_pkg::REM_W+1:0]   w_shift;
    logic [cpr_pkg::REM_W+1:0]   w_trial;
    logic [cpr_pkg::REM_W+1:0]   w_diff;
    logic                        w_ge;

    always_comb begin
        if (r_mode == cpr_pkg::MODE_SQRT) begin
            w_shift = {r_rem, r_a[cpr_pkg::RAD_W-1 -: 2]};
            w_trial = {{(cpr_pkg::REM_W - cpr_pkg::ROOT_W){1'b0}}, r_root, 2'b01};
        end else begin
            w_shift = {1'b0, r_rem, r_a[cpr_pkg::RAD_W-1]};
            w_trial = {{(cpr_pkg::REM_W + 1 - cpr_pkg::N_W){1'b0}}, r_d};
        end
        w_ge   = (w_shift >= w_trial);
        w_diff = w_shift - w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mode <= cpr_pkg::MODE_DIV;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_mode <= i_req.mode;
            r_a    <= i_req.a;
            r_d    <= i_req.d;
            r_root <= '0;
            r_rem  <= '0;
            if (i_req.mode == cpr_pkg::MODE_SQRT) begin
                r_cnt <= cpr_pkg::CNT_W'(cpr_pkg::SQRT_STEPS);
            end else begin
                r_cnt <= cpr_pkg::CNT_W'(cpr_pkg::DIV_STEPS);
            end
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[cpr_pkg::REM_W-1:0] : w_shift[cpr_pkg::REM_W-1:0];
            r_root <= {r_root[cpr_pkg::ROOT_W-2:0], w_ge};
            if (r_mode == cpr_pkg::MODE_SQRT) begin
                r_a <= r_a << 2;
            end else begin
                r_a <= r_a << 1;
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == cpr_pkg::CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_res.busy = r_busy;
    assign o_res.root = r_root;
    assign o_res.rem  = r_rem;

endmodule

// ----- rtl/cosine_polyline_resampler.sv -----
// ----------------------------------------------------------------------------
// Cosine polyline resampler
// Takes control points one beat at a time and emits, for each interval, a
// run of samples with linear x and cosine-blended y. A point is taken in
// IDLE only; the block stays busy until the point is done. The sample-count
// search ends at step k (at most 62), and an interval with no samples skips
// both divisions. A first point skips the interval work and goes to FIN.
// A final point adds one output beat. The work is done by the shared
// restoring root/divide unit (45 steps for the length root, 33 for each of
// two divisions) and by the shared multiplier, which forms the scaled
// squared length in nine passes and each sample's blend product.
// Output beats are held in an output register, so a stalled output only
// pauses the sample loop and the final point's beat. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "cosine_polyline_resampler_assert.svh"

module cosine_polyline_resampler (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic               i_final_point,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_sample_x,
    output logic signed [31:0] o_sample_y,
    output logic               o_run_end
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DIFF      = 4'd1;
    localparam logic [3:0] S_SQ        = 4'd2;
    localparam logic [3:0] S_RM        = 4'd3;
    localparam logic [3:0] S_SQRT_GO   = 4'd4;
    localparam logic [3:0] S_SQRT_WAIT = 4'd5;
    localparam logic [3:0] S_COUNT     = 4'd6;
    localparam logic [3:0] S_DIV1_GO   = 4'd7;
    localparam logic [3:0] S_DIV1_WAIT = 4'd8;
    localparam logic [3:0] S_DIV2_GO   = 4'd9;
    localparam logic [3:0] S_DIV2_WAIT = 4'd10;
    localparam logic [3:0] S_SMUL      = 4'd11;
    localparam logic [3:0] S_SOUT      = 4'd12;
    localparam logic [3:0] S_FIN       = 4'd13;

    logic [3:0]                       r_state;
    logic [2:0]                       r_cnt;
    logic [30:0]                      r_span;
    logic [11:0]                      r_seg;
    logic [31:0]                      r_px;
    logic [31:0]                      r_py;
    logic [31:0]                      r_qx;
    logic [31:0]                      r_qy;
    logic                             r_fin;
    logic                             r_have;
    logic [cpr_pkg::MAG_W-1:0]        r_ax;
    logic [cpr_pkg::MAG_W-1:0]        r_ay;
    logic                             r_negx;
    logic                             r_negy;
    logic [cpr_pkg::LEN2_W-1:0]       r_len2;
    logic [cpr_pkg::SEG2_W-1:0]       r_seg2;
    logic [cpr_pkg::RAD_W-1:0]        r_rad;
    logic [cpr_pkg::ROOT_W:0]         r_s;
    logic [cpr_pkg::N_W-1:0]          r_k;
    logic [36:0]                      r_ks;
    logic [cpr_pkg::N_W-1:0]          r_n;
    logic [cpr_pkg::MAG_W-1:0]        r_qxd;
    logic [cpr_pkg::N_W-1:0]          r_rxd;
    logic [cpr_pkg::TAB_W-1:0]        r_qj;
    logic [cpr_pkg::N_W:0]            r_rj;
    logic [cpr_pkg::N_W-1:0]          r_i;
    logic [cpr_pkg::MAG_W-1:0]        r_qi;
    logic [cpr_pkg::N_W-1:0]          r_ri;
    logic [cpr_pkg::TAB_W-1:0]        r_j;
    logic [cpr_pkg::N_W:0]            r_rja;
    logic                             r_ov;
    logic [31:0]                      r_ox;
    logic [31:0]                      r_oy;
    logic                             r_oe;

    logic [cpr_pkg::MUL_A_W-1:0]      w_ma;
    logic [cpr_pkg::MUL_B_W-1:0]      w_mb;
    logic [cpr_pkg::PROD_W-1:0]       w_prod;
    cpr_pkg::t_iter_req               w_req;
    cpr_pkg::t_iter_res               w_res;

    logic                             w_out_free;
    logic                             w_load;
    logic [32:0]                      w_dx;
    logic [32:0]                      w_dy;
    logic [cpr_pkg::PROD_W:0]         w_pd;
    logic [cpr_pkg::PROD_W:0]         w_sp;
    logic [cpr_pkg::PROD_W:0]         w_rnd;
    logic [31:0]                      w_smp_x;
    logic [31:0]                      w_smp_y;
    logic [cpr_pkg::N_W:0]            w_ri_sum;
    logic [cpr_pkg::N_W+1:0]          w_rj_sum;

    cpr_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    cpr_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    assign w_out_free = !r_ov || !i_out_stall;
    assign w_load     = w_out_free && (r_state == S_SOUT || (r_state == S_FIN && r_fin));
    assign o_in_stall = (r_state != S_IDLE);

    assign w_dx = {r_qx[31], r_qx} - {r_px[31], r_px};
    assign w_dy = {r_qy[31], r_qy} - {r_py[31], r_py};

    assign w_pd    = {1'b0, w_prod};
    assign w_sp    = r_negy ? (~w_pd + 1'b1) : w_pd;
    assign w_rnd   = w_sp + (cpr_pkg::PROD_W+1)'(32768);
    assign w_smp_y = r_py + w_rnd[47:16];
    assign w_smp_x = r_negx ? (r_px - r_qi[31:0]) : (r_px + r_qi[31:0]);

    assign w_ri_sum = {1'b0, r_ri} + {1'b0, r_rxd};
    assign w_rj_sum = {1'b0, r_rja} + {1'b0, r_rj};

    always_comb begin
        w_ma = {1'b0, r_ay};
        w_mb = cpr_pkg::BLEND_TAB[r_j];
        unique case (r_state)
            S_SQ: begin
                case (r_cnt)
                    3'd0: begin
                        w_ma = {1'b0, r_ax};
                        w_mb = r_ax[16:0];
                    end
                    3'd1: begin
                        w_ma = {1'b0, r_ax};
                        w_mb = {1'b0, r_ax[32:17]};
                    end
                    3'd2: begin
                        w_ma = {1'b0, r_ay};
                        w_mb = r_ay[16:0];
                    end
                    3'd3: begin
                        w_ma = {1'b0, r_ay};
                        w_mb = {1'b0, r_ay[32:17]};
                    end
                    default: begin
                        w_ma = cpr_pkg::MUL_A_W'(r_seg);
                        w_mb = cpr_pkg::MUL_B_W'(r_seg);
                    end
                endcase
            end
            S_RM: begin
                w_ma = cpr_pkg::MUL_A_W'(r_seg2);
                case (r_cnt)
                    3'd0:    w_mb = r_len2[16:0];
                    3'd1:    w_mb = r_len2[33:17];
                    3'd2:    w_mb = r_len2[50:34];
                    default: w_mb = {2'b00, r_len2[65:51]};
                endcase
            end
            default: begin
                w_ma = {1'b0, r_ay};
                w_mb = cpr_pkg::BLEND_TAB[r_j];
            end
        endcase
    end

    always_comb begin
        w_req.start = 1'b0;
        w_req.mode  = cpr_pkg::MODE_DIV;
        w_req.a     = '0;
        w_req.d     = '0;
        unique case (r_state)
            S_SQRT_GO: begin
                w_req.start = 1'b1;
                w_req.mode  = cpr_pkg::MODE_SQRT;
                w_req.a     = r_rad;
            end
            S_DIV1_GO: begin
                w_req.start = 1'b1;
                w_req.a     = {r_ax, {(cpr_pkg::RAD_W - cpr_pkg::MAG_W){1'b0}}};
                w_req.d     = {1'b0, r_n};
            end
            S_DIV2_GO: begin
                w_req.start = 1'b1;
                w_req.a     = {cpr_pkg::MAG_W'(2 * cpr_pkg::COS_TABLE_SIZE),
                               {(cpr_pkg::RAD_W - cpr_pkg::MAG_W){1'b0}}};
                w_req.d     = {r_n, 1'b0};
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span <= 31'd65536;
            r_seg  <= 12'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cpr_pkg::CFG_SPAN_X:   r_span <= i_cfg_data;
                cpr_pkg::CFG_SEGMENTS: r_seg  <= i_cfg_data[11:0];
                default:               r_span <= r_span;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_have  <= 1'b0;
            r_px    <= '0;
            r_py    <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (!i_out_stall && !w_load) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_qx    <= i_point_x;
                        r_qy    <= i_point_y;
                        r_fin   <= i_final_point;
                        r_state <= r_have ? S_DIFF : S_FIN;
                    end
                end
                S_DIFF: begin
                    r_negx  <= w_dx[32];
                    r_negy  <= w_dy[32];
                    r_ax    <= w_dx[32] ? (~w_dx + 1'b1) : w_dx;
                    r_ay    <= w_dy[32] ? (~w_dy + 1'b1) : w_dy;
                    r_cnt   <= '0;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    case (r_cnt)
                        3'd1:    r_len2 <= cpr_pkg::LEN2_W'(w_prod);
                        3'd2:    r_len2 <= r_len2 + (cpr_pkg::LEN2_W'(w_prod) << 17);
                        3'd3:    r_len2 <= r_len2 + cpr_pkg::LEN2_W'(w_prod);
                        3'd4:    r_len2 <= r_len2 + (cpr_pkg::LEN2_W'(w_prod) << 17);
                        3'd5:    r_seg2 <= w_prod[cpr_pkg::SEG2_W-1:0];
                        default: r_len2 <= r_len2;
                    endcase
                    if (r_cnt == 3'd5) begin
                        r_cnt   <= '0;
                        r_state <= S_RM;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_RM: begin
                    case (r_cnt)
                        3'd1:    r_rad <= cpr_pkg::RAD_W'(w_prod);
                        3'd2:    r_rad <= r_rad + (cpr_pkg::RAD_W'(w_prod) << 17);
                        3'd3:    r_rad <= r_rad + (cpr_pkg::RAD_W'(w_prod) << 34);
                        3'd4:    r_rad <= r_rad + (cpr_pkg::RAD_W'(w_prod) << 51);
                        default: r_rad <= r_rad;
                    endcase
                    if (r_cnt == 3'd4) begin
                        r_state <= S_SQRT_GO;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SQRT_GO: begin
                    r_state <= S_SQRT_WAIT;
                end
                S_SQRT_WAIT: begin
                    if (!w_res.busy) begin
                        r_s     <= {1'b0, w_res.root} + (cpr_pkg::ROOT_W+1)'(w_res.rem != '0);
                        r_k     <= '0;
                        r_ks    <= '0;
                        r_state <= S_COUNT;
                    end
                end
                S_COUNT: begin
                    if ({9'd0, r_ks} >= r_s) begin
                        r_n     <= r_k;
                        r_state <= (r_k == '0) ? S_FIN : S_DIV1_GO;
                    end else if (r_k == cpr_pkg::N_W'(cpr_pkg::MAX_PER_INTERVAL - 1)) begin
                        r_n     <= cpr_pkg::N_W'(cpr_pkg::MAX_PER_INTERVAL);
                        r_state <= S_DIV1_GO;
                    end else begin
                        r_k  <= r_k + 1'b1;
                        r_ks <= r_ks + 37'(r_span);
                    end
                end
                S_DIV1_GO: begin
                    r_state <= S_DIV1_WAIT;
                end
                S_DIV1_WAIT: begin
                    if (!w_res.busy) begin
                        r_qxd   <= w_res.root[cpr_pkg::MAG_W-1:0];
                        r_rxd   <= w_res.rem[cpr_pkg::N_W-1:0];
                        r_state <= S_DIV2_GO;
                    end
                end
                S_DIV2_GO: begin
                    r_state <= S_DIV2_WAIT;
                end
                S_DIV2_WAIT: begin
                    if (!w_res.busy) begin
                        r_qj    <= w_res.root[cpr_pkg::TAB_W-1:0];
                        r_rj    <= w_res.rem[cpr_pkg::N_W:0];
                        r_i     <= '0;
                        r_qi    <= '0;
                        r_ri    <= '0;
                        r_j     <= '0;
                        r_rja   <= {1'b0, r_n};
                        r_state <= S_SMUL;
                    end
                end
                S_SMUL: begin
                    r_state <= S_SOUT;
                end
                S_SOUT: begin
                    if (w_out_free) begin
                        r_ov <= 1'b1;
                        r_ox <= w_smp_x;
                        r_oy <= w_smp_y;
                        r_oe <= (r_i == r_n - 1'b1) && !r_fin;
                        if (w_ri_sum >= {1'b0, r_n}) begin
                            r_ri <= cpr_pkg::N_W'(w_ri_sum - {1'b0, r_n});
                            r_qi <= r_qi + r_qxd + 1'b1;
                        end else begin
                            r_ri <= w_ri_sum[cpr_pkg::N_W-1:0];
                            r_qi <= r_qi + r_qxd;
                        end
                        if (w_rj_sum >= {1'b0, r_n, 1'b0}) begin
                            r_rja <= (cpr_pkg::N_W+1)'(w_rj_sum - {1'b0, r_n, 1'b0});
                            r_j   <= r_j + r_qj + 1'b1;
                        end else begin
                            r_rja <= w_rj_sum[cpr_pkg::N_W:0];
                            r_j   <= r_j + r_qj;
                        end
                        r_i     <= r_i + 1'b1;
                        r_state <= (r_i == r_n - 1'b1) ? S_FIN : S_SMUL;
                    end
                end
                S_FIN: begin
                    if (!r_fin || w_out_free) begin
                        if (r_fin) begin
                            r_ov <= 1'b1;
                            r_ox <= r_qx;
                            r_oy <= r_qy;
                            r_oe <= 1'b1;
                        end
                        r_px    <= r_qx;
                        r_py    <= r_qy;
                        r_have  <= !r_fin;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_sample_x  = r_ox;
    assign o_sample_y  = r_oy;
    assign o_run_end   = r_oe;

    `CPR_ASSERT_IMP(a_tab_index, r_state == S_SOUT, r_j <= cpr_pkg::TAB_W'(cpr_pkg::COS_TABLE_SIZE))
    `CPR_ASSERT_IMP(a_x_remainder, r_state == S_SOUT, r_ri < r_n)
    `CPR_ASSERT_NXT(a_accept_next, i_in_valid && !o_in_stall, r_state == S_DIFF || r_state == S_FIN)
    `CPR_ASSERT_NXT(a_last_beat, r_state == S_SOUT && w_out_free && r_i == r_n - 1'b1, o_out_valid && (o_run_end == !r_fin))

endmodule

// ----- test/cosine_polyline_resampler_test.sv -----
// ----------------------------------------------------------------------------
// Cosine polyline resampler testbench
// Drives control points through the resampler under several idling patterns
// and register settings, predicts every sample beat with a local model of
// the sample-count search and the cosine blend, and compares each output
// beat field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cosine_polyline_resampler_test;

    typedef struct {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic               last;
    } t_sample;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [0:0]         i_cfg_index = cpr_pkg::CFG_SPAN_X;
    logic [30:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [31:0] i_point_x = '0;
    logic signed [31:0] i_point_y = '0;
    logic               i_final_point = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_sample_x;
    logic signed [31:0] o_sample_y;
    logic               o_run_end;

    cosine_polyline_resampler uut (.*);

    always #6 i_clk = ~i_clk;

    t_sample          pending_samples[$];
    int               mismatch_count = 0;
    int               send_idle_pct = 0;
    int               stall_pct = 0;
    int               hold_cycles = 0;
    logic [16:0]      blend_lut [0:cpr_pkg::COS_TABLE_SIZE];
    longint unsigned  span_reg;
    longint unsigned  seg_reg;
    longint           last_x;
    longint           last_y;
    bit               have_last;

    function automatic longint unsigned cosine_q30(longint unsigned ang);
        longint unsigned x2;
        longint unsigned r;
        longint unsigned term;
        longint unsigned divs [6];
        divs = '{132, 90, 56, 30, 12, 2};
        x2 = (ang * ang + (64'd1 << 29)) >> 30;
        r = 64'd1 << 30;
        for (int k = 0; k < 6; k++) begin
            term = ((x2 * r) >> 30) / divs[k];
            if (term > (64'd1 << 30)) begin
                term = 64'd1 << 30;
            end
            r = (64'd1 << 30) - term;
        end
        return r;
    endfunction

    task automatic fill_blend_lut();
        longint unsigned v;
        longint unsigned pi_q = 64'd3373259426;
        for (int j = 0; j <= cpr_pkg::COS_TABLE_SIZE; j++) begin
            if (2 * j <= cpr_pkg::COS_TABLE_SIZE) begin
                v = (64'd1 << 30) - cosine_q30(pi_q * j / cpr_pkg::COS_TABLE_SIZE);
            end else begin
                v = (64'd1 << 30) + cosine_q30(pi_q * (cpr_pkg::COS_TABLE_SIZE - j)
                                               / cpr_pkg::COS_TABLE_SIZE);
            end
            blend_lut[j] = 17'((v + (64'd1 << 14)) >> 15);
        end
    endtask

    function automatic int interval_count(longint dx, longint dy);
        logic [127:0] len2;
        logic [127:0] rhs;
        logic [127:0] ks;
        longint unsigned ax;
        longint unsigned ay;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        len2 = 128'(ax * ax) + 128'(ay * ay);
        rhs = len2 * 128'(seg_reg * seg_reg);
        for (int k = 0; k < cpr_pkg::MAX_PER_INTERVAL; k++) begin
            ks = 128'(k) * 128'(span_reg);
            if (ks * ks >= rhs) begin
                return k;
            end
        end
        return cpr_pkg::MAX_PER_INTERVAL;
    endfunction

    task automatic predict_point(logic signed [31:0] px, logic signed [31:0] py, logic fin);
        longint  dx;
        longint  dy;
        longint  prod;
        int      n;
        int      j;
        t_sample s;
        int      first = pending_samples.size();
        if (have_last) begin
            dx = longint'(px) - last_x;
            dy = longint'(py) - last_y;
            n = interval_count(dx, dy);
            for (int i = 0; i < n; i++) begin
                j = (2 * i * cpr_pkg::COS_TABLE_SIZE + n) / (2 * n);
                prod = dy * longint'(blend_lut[j]);
                s.sx = 32'(last_x + (dx * i) / n);
                s.sy = 32'(last_y + ((prod + 64'sd32768) >>> 16));
                s.last = 1'b0;
                pending_samples.push_back(s);
            end
        end
        if (fin) begin
            s.sx = px;
            s.sy = py;
            s.last = 1'b0;
            pending_samples.push_back(s);
        end
        if (pending_samples.size() > first) begin
            pending_samples[pending_samples.size() - 1].last = 1'b1;
        end
        have_last = !fin;
        last_x = px;
        last_y = py;
    endtask

    always @(posedge i_clk) begin
        t_sample s;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_samples.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Unexpected sample beat x=%0d y=%0d end=%0b",
                             o_sample_x, o_sample_y, o_run_end);
                end
            end else begin
                s = pending_samples.pop_front();
                if (s.sx !== o_sample_x || s.sy !== o_sample_y || s.last !== o_run_end) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Sample mismatch: expected x=%0d y=%0d end=%0b, got x=%0d y=%0d end=%0b",
                                 s.sx, s.sy, s.last, o_sample_x, o_sample_y, o_run_end);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_point(logic signed [31:0] px, logic signed [31:0] py, logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_point_x <= px;
        i_point_y <= py;
        i_final_point <= fin;
        i_in_valid <= 1'b1;
        predict_point(px, py, fin);
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] index, logic [30:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == cpr_pkg::CFG_SPAN_X) begin
            span_reg = value;
        end else begin
            seg_reg = value[11:0];
        end
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_point(32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
        send_point(32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
        send_point(32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
        send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1);
        send_point(0, 0, 1'b1);
        send_point(0, 0, 1'b0);
        send_point(32'sd4096, 32'sd1000, 1'b0);
        send_point(32'sd20000, -32'sd30000, 1'b0);
        send_point(32'sd65536, 32'sd65536, 1'b1);
        send_point(-32'sd5, 32'sd5, 1'b0);
        send_point(-32'sd5, 32'sd5, 1'b1);
    endtask

    task automatic test_random_curves(int points);
        longint x;
        int     sent = 0;
        int     len;
        while (sent < points) begin
            len = $urandom_range(6, 1);
            x = $signed($urandom_range(32'hffff, 0)) - 32768;
            for (int k = 0; k < len && sent < points; k++) begin
                if ($urandom_range(9) == 0) begin
                    send_point($urandom, $urandom, 1'($urandom_range(1)));
                end else begin
                    x = x + $urandom_range(40000);
                    send_point(32'(x), 32'($signed($urandom_range(200000)) - 100000),
                               k == len - 1);
                end
                sent++;
            end
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 3000;
        send_point(0, 0, 1'b0);
        send_point(32'sd30000, 32'sd30000, 1'b0);
        send_point(32'sd60000, -32'sd30000, 1'b0);
        send_point(32'sd90000, 32'sd0, 1'b1);
        wait_drained();
    endtask

    initial begin
        span_reg = 65536;
        seg_reg = 64;
        have_last = 1'b0;
        fill_blend_lut();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_drained();
        send_idle_pct = 64;
        write_reg(cpr_pkg::CFG_SPAN_X, 31'd1);
        write_reg(cpr_pkg::CFG_SEGMENTS, 31'd4095);
        test_random_curves(25);
        wait_drained();
        send_idle_pct = 0;
        stall_pct = 64;
        write_reg(cpr_pkg::CFG_SPAN_X, 31'h7fff_ffff);
        write_reg(cpr_pkg::CFG_SEGMENTS, 31'd1);
        test_directed();
        test_random_curves(15);
        wait_drained();
        write_reg(cpr_pkg::CFG_SPAN_X, 31'd0);
        write_reg(cpr_pkg::CFG_SEGMENTS, 31'd0);
        test_random_curves(10);
        wait_drained();
        send_idle_pct = 26;
        stall_pct = 26;
        write_reg(cpr_pkg::CFG_SPAN_X, 31'd0);
        write_reg(cpr_pkg::CFG_SEGMENTS, 31'd10);
        test_random_curves(15);
        wait_drained();
        write_reg(cpr_pkg::CFG_SPAN_X, 31'd400000);
        write_reg(cpr_pkg::CFG_SEGMENTS, 31'd20);
        test_random_curves(50);
        wait_drained();
        send_idle_pct = 0;
        stall_pct = 0;
        write_reg(cpr_pkg::CFG_SPAN_X, 31'd65536);
        write_reg(cpr_pkg::CFG_SEGMENTS, 31'd64);
        test_random_curves(25);
        wait_drained();
        test_backpressure();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/cpr_pkg.sv
rtl/cpr_mul.sv
rtl/cpr_iter.sv
rtl/cosine_polyline_resampler.sv
test/cosine_polyline_resampler_test.sv
